### rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int REQ_W     = 3;
  localparam int VALUE_W   = 64;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 9;

  typedef enum logic [REQ_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic take;
    op_t  op;
  } cmd_t;

endpackage

### rtl/core/deq_ctrl.sv
// Handshake controller for the double-ended queue.
module deq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [deq_pkg::REQ_W-1:0]     req_type,
  output logic                          out_valid,
  input  logic                          out_ready,
  output deq_pkg::cmd_t                 cmd
);
  import deq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_valid  = 1'b0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        // take the next transaction in the cycle the result leaves
        in_ready  = out_ready;
        if (out_ready && !in_valid) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.take = in_valid && in_ready;
    cmd.op   = op_t'(req_type);
  end

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> out_valid)
    else $error("accepted request did not raise a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_ready) |-> out_ready)
    else $error("new request accepted over a pending result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped before it was taken");

endmodule

### rtl/core/deq_dpath.sv
// Ring store, front and count pointers, and result register of the queue.
module deq_dpath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  deq_pkg::cmd_t                        cmd,
  input  logic signed [deq_pkg::VALUE_W-1:0]   value,
  input  logic [deq_pkg::INDEX_W-1:0]          index,
  output logic signed [deq_pkg::VALUE_W-1:0]   read_value,
  output logic [deq_pkg::STATUS_W-1:0]         status,
  output logic [deq_pkg::ENTRIES_W-1:0]        entries
);
  import deq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic [PW-1:0] front, front_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          rd_ok, rd_ok_next;
  logic [STATUS_W-1:0] st_next;

  logic          full, empty, in_range;
  logic [PW-1:0] off, ring_addr, addr, front_inc, front_dec;
  logic [PW:0]   sum_a, sum_b;
  logic          use_dec, wr_en, rd_en;

  assign full     = (cnt == DEPTH_C);
  assign empty    = (cnt == '0);
  assign in_range = (IW'(index) < IW'(cnt));

  // Wrap front plus offset back into the ring.
  assign sum_a     = {1'b0, front} + {1'b0, off};
  assign ring_addr = (sum_a >= DEPTH_W) ? PW'(sum_a - DEPTH_W) : sum_a[PW-1:0];
  assign sum_b     = {1'b0, front} + (PW+1)'(1);
  assign front_inc = (sum_b >= DEPTH_W) ? PW'(sum_b - DEPTH_W) : sum_b[PW-1:0];
  assign front_dec = (front == '0) ? LAST_P : front - PW'(1);
  assign addr      = use_dec ? front_dec : ring_addr;

  always_comb begin
    off        = '0;
    use_dec    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_ok_next = 1'b0;
    st_next    = ST_OK;
    cnt_next   = cnt;
    front_next = front;
    case (cmd.op)
      OP_PUSH_BACK: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          off      = cnt[PW-1:0];
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          use_dec    = 1'b1;
          wr_en      = 1'b1;
          front_next = front_dec;
          cnt_next   = cnt + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          off        = PW'(cnt - CW'(1));
          rd_en      = 1'b1;
          rd_ok_next = 1'b1;
          cnt_next   = cnt - CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          rd_ok_next = 1'b1;
          front_next = front_inc;
          cnt_next   = cnt - CW'(1);
        end
      end
      OP_READ: begin
        if (!in_range) begin
          st_next = ST_EMPTY;
        end else begin
          off        = PW'(index);
          rd_en      = 1'b1;
          rd_ok_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        front_next = '0;
        cnt_next   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
    end else if (cmd.take) begin
      front <= front_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[addr] <= value;
    end
    if (cmd.take && rd_en) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_ok   <= rd_ok_next;
      status  <= st_next;
      entries <= ENTRIES_W'(cnt_next);
    end
  end

  assign read_value = rd_ok ? $signed(rdata) : '0;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("entry count above depth");

  a_full_push_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && full && (cmd.op == OP_PUSH_BACK || cmd.op == OP_PUSH_FRONT))
    |=> (status == ST_FULL && cnt == $past(cnt) && front == $past(front)))
    else $error("push on full queue changed state");

  a_empty_pop_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && empty && (cmd.op == OP_POP_BACK || cmd.op == OP_POP_FRONT))
    |=> (status == ST_EMPTY && cnt == $past(cnt) && front == $past(front)))
    else $error("pop on empty queue changed state");

endmodule

### rtl/core/double_ended_queue.sv
// Result: valid in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle while results are taken at once; a new
//   request is taken in the same cycle the pending result leaves, set by the
//   single-port ring store and the one result register.
// Reset (rst, synchronous): empties the queue (front and count to zero), no result
//   pending; ring store contents are left as they are.
// Top level of the double-ended queue: controller plus ring-store datapath.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [deq_pkg::REQ_W-1:0]            req_type,
  input  logic signed [deq_pkg::VALUE_W-1:0]   value,
  input  logic [deq_pkg::INDEX_W-1:0]          index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [deq_pkg::VALUE_W-1:0]   read_value,
  output logic [deq_pkg::STATUS_W-1:0]         status,
  output logic [deq_pkg::ENTRIES_W-1:0]        entries
);
  import deq_pkg::*;

  // Command from the controller: accept this cycle, and the decoded request.
  cmd_t cmd;

  // Handshake and sequencing: hold one result until it is taken, and
  // take the next transaction in that same cycle when one is offered.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Pointers, ring store and result register. Pushes write the store and
  // pops or reads register the store output; a failed request returns zero.
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .index      (index),
    .read_value (read_value),
    .status     (status),
    .entries    (entries)
  );

endmodule
